[src/tfr_pkg.sv]
// tfr_pkg: shared types and constants of the TLV field reader.
// Used by every module of the block and by its checker; depends on nothing.
package tfr_pkg;

    localparam int unsigned TFR_QDEPTH = 4;

    localparam logic [2:0]  HDR_BYTES    = 3'd6;
    localparam logic [2:0]  HDR_TAG_IDX  = 3'd0;
    localparam logic [2:0]  HDR_TYPE_IDX = 3'd1;
    localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;

    localparam logic [1:0] REC_FIELD = 2'd0;
    localparam logic [1:0] REC_END   = 2'd1;
    localparam logic [1:0] REC_TRUNC = 2'd2;

    // One queue entry: everything one byte produces (one or two records).
    typedef struct packed {
        logic        has_field;
        logic        has_term;
        logic        term_trunc;
        logic [7:0]  tag;
        logic [7:0]  ftype;
        logic [31:0] length;
        logic [31:0] offset;
    } t_event;

endpackage

[src/tfr_front.sv]
// tfr_front: byte-serial header and payload tracker of the TLV field reader.
// Classifies each transferred byte and produces at most one event per byte.
// Depends on tfr_pkg.
module tfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_message,
    output logic          o_ev_valid,
    output tfr_pkg::t_event o_ev
);
    import tfr_pkg::*;

    logic        r_in_payload, n_in_payload;
    logic [2:0]  r_hc, n_hc;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_len, n_len;
    logic [31:0] r_left, n_left;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_start, n_start;
    logic [31:0] w_next_pos;
    logic [2:0]  w_hc_inc;
    logic        w_fld;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hc         = r_hc;
        n_tag        = r_tag;
        n_type       = r_type;
        n_len        = r_len;
        n_left       = r_left;
        n_start      = r_start;
        w_next_pos   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 32'd1;
        n_pos        = w_next_pos;
        w_hc_inc     = r_hc + 3'd1;
        w_fld        = 1'b0;

        if (r_in_payload) begin
            n_left = r_left - 32'd1;
            if (n_left == 32'd0) begin
                w_fld        = 1'b1;
                n_in_payload = 1'b0;
                n_hc         = 3'd0;
            end
        end else begin
            case (r_hc)
                HDR_TAG_IDX: begin
                    n_tag = i_data_byte;
                    n_len = 32'd0;
                end
                HDR_TYPE_IDX: begin
                    n_type = i_data_byte;
                end
                default: begin
                    n_len = {r_len[23:0], i_data_byte};
                end
            endcase
            n_hc = w_hc_inc;
            if (w_hc_inc == HDR_BYTES) begin
                n_hc    = 3'd0;
                n_start = w_next_pos;
                n_left  = n_len;
                if (n_len == 32'd0) begin
                    w_fld = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                end
            end
        end

        o_ev.has_field  = w_fld;
        o_ev.has_term   = i_end_of_message;
        o_ev.term_trunc = n_in_payload;
        o_ev.tag        = n_tag;
        o_ev.ftype      = n_type;
        o_ev.length     = n_len;
        o_ev.offset     = n_start;
        o_ev_valid      = i_valid && (w_fld || i_end_of_message);

        if (i_end_of_message) begin
            n_in_payload = 1'b0;
            n_hc         = 3'd0;
            n_tag        = 8'd0;
            n_type       = 8'd0;
            n_len        = 32'd0;
            n_left       = 32'd0;
            n_pos        = 32'd0;
            n_start      = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hc         <= 3'd0;
            r_tag        <= 8'd0;
            r_type       <= 8'd0;
            r_len        <= 32'd0;
            r_left       <= 32'd0;
            r_pos        <= 32'd0;
            r_start      <= 32'd0;
        end else if (i_valid) begin
            r_in_payload <= n_in_payload;
            r_hc         <= n_hc;
            r_tag        <= n_tag;
            r_type       <= n_type;
            r_len        <= n_len;
            r_left       <= n_left;
            r_pos        <= n_pos;
            r_start      <= n_start;
        end
    end

endmodule

[src/tfr_evq.sv]
// tfr_evq: small event queue between front and back of the TLV field reader.
// Register array with wrap-around pointers and an occupancy count. Depends on tfr_pkg.
module tfr_evq #(
    parameter int unsigned DEPTH = tfr_pkg::TFR_QDEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfr_pkg::t_event i_data,
    output logic            o_full,
    input  logic            i_pop,
    output tfr_pkg::t_event o_data,
    output logic            o_empty
);
    import tfr_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_event          r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_FULL);
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[src/tfr_back.sv]
// tfr_back: result stage of the TLV field reader.
// Holds one event and expands it into one or two records. Depends on tfr_pkg.
module tfr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  tfr_pkg::t_event i_q_data,
    output logic            o_q_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [1:0]      o_record_kind,
    output logic [7:0]      o_field_tag,
    output logic [7:0]      o_field_type,
    output logic [31:0]     o_field_length,
    output logic [31:0]     o_value_offset,
    output logic            o_last_record
);
    import tfr_pkg::*;

    t_event r_ev;
    logic   r_valid;
    logic   r_second;
    logic   w_xfer, w_split, w_done, w_load;
    logic   w_term_only;

    assign w_xfer   = i_pop && r_valid;
    assign w_split  = !r_second && r_ev.has_field && r_ev.has_term;
    assign w_done   = w_xfer && !w_split;
    assign w_load   = (!r_valid || w_done) && !i_q_empty;
    assign o_q_pop  = w_load;
    assign o_empty  = !r_valid;

    // term record: second of a pair, or the only record of the event
    assign w_term_only = r_second || !r_ev.has_field;

    always_comb begin
        if (w_term_only && !(r_ev.term_trunc && !r_second)) begin
            o_record_kind  = REC_END;
            o_field_tag    = 8'd0;
            o_field_type   = 8'd0;
            o_field_length = 32'd0;
            o_value_offset = 32'd0;
            o_last_record  = 1'b1;
        end else begin
            o_record_kind  = w_term_only ? REC_TRUNC : REC_FIELD;
            o_field_tag    = r_ev.tag;
            o_field_type   = r_ev.ftype;
            o_field_length = r_ev.length;
            o_value_offset = r_ev.offset;
            o_last_record  = w_term_only || !r_ev.has_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ev <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (w_xfer && w_split) begin
            r_second <= 1'b1;
        end else if (w_load) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (w_done) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end
    end

endmodule

[src/tlv_field_reader.sv]
// tlv_field_reader: top level of the TLV field reader.
// Instantiates tfr_front, tfr_evq and tfr_back; depends on tfr_pkg.
//
// Usage:
//   Input queue side: one message byte and its end-of-message mark per
//   transfer (push high while full low). Bytes are taken at one per clock
//   whenever the event queue has room; full depends only on queue occupancy.
//   Result queue side: while empty is low the oldest record is on the o_
//   ports; pop high takes it. One record leaves per clock while pop is high.
//   A byte that completes a field or ends a message produces one event, which
//   is expanded into one record, or two when a field record precedes the end
//   record. When nothing is queued ahead of them, records are shown once the
//   event has been written into the event queue and loaded into tfr_back.
//   Sustained rate: one byte per cycle while full is low; records drain at
//   one per cycle while pop is high; the QDEPTH-entry event queue absorbs
//   the extra output time of a byte that causes two records.
//   While pop stays low the shown record holds, the queue fills and full
//   rises; no byte is lost.
//   Synchronous reset clears parser state, queue and result stage; empty is
//   high and full low after the reset edge.
module tlv_field_reader #(
    parameter int unsigned QDEPTH = tfr_pkg::TFR_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_record_kind,
    output logic [7:0]  o_field_tag,
    output logic [7:0]  o_field_type,
    output logic [31:0] o_field_length,
    output logic [31:0] o_value_offset,
    output logic        o_last_record
);
    import tfr_pkg::*;

    logic   w_accept;
    logic   w_ev_valid;
    t_event w_ev;
    t_event w_q_data;
    logic   w_q_full, w_q_empty, w_q_pop;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    tfr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_ev_valid       (w_ev_valid),
        .o_ev             (w_ev)
    );

    tfr_evq #(
        .DEPTH (QDEPTH)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ev_valid),
        .i_data  (w_ev),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    tfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_q_data       (w_q_data),
        .o_q_pop        (w_q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_record_kind  (o_record_kind),
        .o_field_tag    (o_field_tag),
        .o_field_type   (o_field_type),
        .o_field_length (o_field_length),
        .o_value_offset (o_value_offset),
        .o_last_record  (o_last_record)
    );

endmodule

[src/tfr_checker.sv]
// tfr_checker: port-level assertions for tlv_field_reader, with its bind.
// Depends on tfr_pkg.
module tfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_record_kind,
    input logic [7:0]  o_field_tag,
    input logic [7:0]  o_field_type,
    input logic [31:0] o_field_length,
    input logic [31:0] o_value_offset,
    input logic        o_last_record
);
    import tfr_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == REC_END) |->
        (o_field_tag == 8'd0 && o_field_type == 8'd0 && o_field_length == 32'd0
         && o_value_offset == 32'd0 && o_last_record))
        else $error("end record carries non-zero fields");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == REC_TRUNC) |-> o_last_record)
        else $error("truncation record not last");

    a_pair_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_record_kind == REC_FIELD && !o_last_record) |=>
        (!empty && o_record_kind == REC_END))
        else $error("field record not followed by end record");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_record_kind)
                              && $stable(o_value_offset)))
        else $error("stalled record changed");

endmodule

bind tlv_field_reader tfr_checker u_tfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_record_kind  (o_record_kind),
    .o_field_tag    (o_field_tag),
    .o_field_type   (o_field_type),
    .o_field_length (o_field_length),
    .o_value_offset (o_value_offset),
    .o_last_record  (o_last_record)
);
